FILE: design/oldest_entry_eviction_with_locks_assert.svh
// assertion macros used by the top design file
`ifndef OLDEST_ENTRY_EVICTION_WITH_LOCKS_ASSERT_SVH
`define OLDEST_ENTRY_EVICTION_WITH_LOCKS_ASSERT_SVH

// property holds in the same cycle as its antecedent
`define OEEL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// property holds in the cycle after its antecedent
`define OEEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/oeel_pkg.sv
package oeel_pkg;

   localparam int KEY_W         = 64;
   localparam int TIME_W        = 32;
   localparam int LIMIT_W       = 6;
   localparam int IDX_MAX_W     = 6;
   localparam int DEF_TABLE_DEPTH = 32;
   localparam int DEF_LOCK_DEPTH  = 16;
   localparam int MAX_RESULTS   = 32;
   localparam int NEV_W         = $clog2(MAX_RESULTS + 1);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   localparam logic [2:0] KIND_ADD       = 3'd0;
   localparam logic [2:0] KIND_LOCK      = 3'd1;
   localparam logic [2:0] KIND_UNLOCK    = 3'd2;
   localparam logic [2:0] KIND_CLEAR_ONE = 3'd3;
   localparam logic [2:0] KIND_CLEAR_ALL = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
   localparam logic [1:0] STATUS_LOCK_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]        kind;
      logic [KEY_W-1:0]  entry_key;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
      logic             last;
   } rsp_type;

   // controls into one slot cell
   typedef struct packed {
      logic wr_new;
      logic set_time;
      logic set_lock;
      logic clr_lock;
      logic invalidate;
   } slot_ctl_type;

   // controls into one lock cell
   typedef struct packed {
      logic write;
      logic clear;
   } lock_ctl_type;

   // running oldest-unlocked candidate passed along the slot row
   typedef struct packed {
      logic                 found;
      logic [IDX_MAX_W-1:0] idx;
      logic [KEY_W-1:0]     key;
      logic [TIME_W-1:0]    stamp;
   } best_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_SCAN,
      ST_EVICT
   } state_type;

endpackage

FILE: design/oeel_slot_cell.sv
module oeel_slot_cell #(
   parameter int SLOT_INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  oeel_pkg::slot_ctl_type    ctl,
   input  logic [oeel_pkg::KEY_W-1:0]  cmp_key,
   input  logic [oeel_pkg::TIME_W-1:0] wr_time,
   input  logic                      wr_lock,
   input  oeel_pkg::best_type        prev,
   output oeel_pkg::best_type        best,
   output logic                      hit,
   output logic                      valid
);
   import oeel_pkg::*;

   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] time_ff;
   logic              valid_ff, valid_in;
   logic              locked_ff;
   best_type          best_ff, best_in;

   assign hit   = valid_ff && (key_ff == cmp_key);
   assign valid = valid_ff;
   assign best  = best_ff;

   // valid bit
   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_new) valid_in = 1'b1;
      if (ctl.invalidate) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (ctl.wr_new) begin
         key_ff    <= cmp_key;
         time_ff   <= wr_time;
         locked_ff <= wr_lock;
      end else begin
         if (ctl.set_time) time_ff <= wr_time;
         if (ctl.set_lock) locked_ff <= 1'b1;
         if (ctl.clr_lock) locked_ff <= 1'b0;
      end
   end

   // older own entry replaces the candidate, lower slot wins on ties
   always_comb begin
      best_in = prev;
      if (valid_ff && !locked_ff && (!prev.found || time_ff < prev.stamp)) begin
         best_in.found = 1'b1;
         best_in.idx   = IDX_MAX_W'(SLOT_INDEX);
         best_in.key   = key_ff;
         best_in.stamp = time_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

endmodule

FILE: design/oeel_lock_cell.sv
module oeel_lock_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  oeel_pkg::lock_ctl_type     ctl,
   input  logic [oeel_pkg::KEY_W-1:0] cmp_key,
   output logic                       hit,
   output logic                       valid
);
   import oeel_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic             valid_ff;

   assign hit   = valid_ff && (key_ff == cmp_key);
   assign valid = valid_ff;

   // lock entry valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.write) begin
         valid_ff <= 1'b1;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) key_ff <= cmp_key;
   end

endmodule

FILE: design/oldest_entry_eviction_with_locks.sv
// lock, unlock and clear: the request is taken in IDLE, executed in EXEC, then the result strobe is registered
// add: EXEC, then CHECK; each eviction runs SCAN, the age search walking the slot row, then EVICT
// one item at a time; busy falls in the cycle that carries the last result of the item
// results cannot be stalled: each is on rsp_data for one cycle with rsp_strobe
// synchronous reset empties table and lock set and sets the limit to 32
module oldest_entry_eviction_with_locks #(
   parameter int TABLE_DEPTH = oeel_pkg::DEF_TABLE_DEPTH,
   parameter int LOCK_DEPTH  = oeel_pkg::DEF_LOCK_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  oeel_pkg::req_type            req_data,
   output logic                         rsp_strobe,
   output oeel_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [oeel_pkg::LIMIT_W-1:0] csr_wr_data
);
   import oeel_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SCAN_W = $clog2(TABLE_DEPTH);
   localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [NEV_W-1:0]   nev_ff, nev_in;
   logic [1:0]         status_ff, status_in;
   logic               pend_ff, pend_in;
   logic [KEY_W-1:0]   pend_key_ff, pend_key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   slot_ctl_type       slot_ctl [TABLE_DEPTH];
   lock_ctl_type       lock_ctl [LOCK_DEPTH];
   best_type           chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] slot_hit, slot_valid, slot_free_oh;
   logic [LOCK_DEPTH-1:0]  lock_hit, lock_valid, lock_free_oh;
   logic               any_slot_hit, any_lock_hit, slot_room, lock_room;
   logic               over_limit;
   best_type           tail;

   // slot row
   assign chain[0] = '0;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
      oeel_slot_cell #(.SLOT_INDEX(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (slot_ctl[i]),
         .cmp_key (req_ff.entry_key),
         .wr_time (req_ff.now_time),
         .wr_lock (any_lock_hit),
         .prev    (chain[i]),
         .best    (chain[i+1]),
         .hit     (slot_hit[i]),
         .valid   (slot_valid[i])
      );
   end

   // lock set
   for (genvar j = 0; j < LOCK_DEPTH; j++) begin : g_lock
      oeel_lock_cell u_lock (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lock_ctl[j]),
         .cmp_key (req_ff.entry_key),
         .hit     (lock_hit[j]),
         .valid   (lock_valid[j])
      );
   end

   assign tail         = chain[TABLE_DEPTH];
   assign any_slot_hit = |slot_hit;
   assign any_lock_hit = |lock_hit;
   assign slot_room    = ~&slot_valid;
   assign lock_room    = ~&lock_valid;
   assign slot_free_oh = ~slot_valid & (slot_valid + 1'b1);
   assign lock_free_oh = ~lock_valid & (lock_valid + 1'b1);
   assign over_limit   = CMP_W'(count_ff) > CMP_W'(limit_ff);
   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // per-cell controls
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_ctl[i] = '0;
      end
      for (int j = 0; j < LOCK_DEPTH; j++) begin
         lock_ctl[j] = '0;
      end
      if (state_ff == ST_EXEC) begin
         case (req_ff.kind)
            KIND_ADD: begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  slot_ctl[i].wr_new = !any_slot_hit && slot_free_oh[i];
               end
            end
            KIND_LOCK: begin
               for (int j = 0; j < LOCK_DEPTH; j++) begin
                  lock_ctl[j].write = !any_lock_hit && lock_free_oh[j];
               end
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  slot_ctl[i].set_time = slot_hit[i];
                  slot_ctl[i].set_lock = slot_hit[i] && (any_lock_hit || lock_room);
               end
            end
            KIND_UNLOCK: begin
               for (int j = 0; j < LOCK_DEPTH; j++) begin
                  lock_ctl[j].clear = lock_hit[j];
               end
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  slot_ctl[i].clr_lock = slot_hit[i];
               end
            end
            KIND_CLEAR_ONE: begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  slot_ctl[i].invalidate = slot_hit[i];
               end
            end
            KIND_CLEAR_ALL: begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  slot_ctl[i].invalidate = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (state_ff == ST_EVICT) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_ctl[i].invalidate = tail.found && (tail.idx == IDX_MAX_W'(i));
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      nev_in       = nev_ff;
      status_in    = status_ff;
      pend_in      = pend_ff;
      pend_key_in  = pend_key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            nev_in    = '0;
            pend_in   = 1'b0;
            case (req_ff.kind)
               KIND_ADD: begin
                  if (!any_slot_hit) begin
                     if (slot_room) count_in = count_ff + 1'b1;
                     else status_in = STATUS_TABLE_FULL;
                  end
               end
               KIND_LOCK: begin
                  if (!any_lock_hit && !lock_room) status_in = STATUS_LOCK_FULL;
               end
               KIND_CLEAR_ONE: begin
                  if (any_slot_hit) count_in = count_ff - 1'b1;
               end
               KIND_CLEAR_ALL: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
            if (req_ff.kind == KIND_ADD) begin
               state_in = ST_CHECK;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_in, evicted: 1'b0, evicted_key: '0, last: 1'b1};
               state_in     = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (over_limit && (nev_ff < NEV_W'(MAX_RESULTS))) begin
               scan_in  = '0;
               state_in = ST_SCAN;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: status_ff, evicted: pend_ff,
                          evicted_key: pend_ff ? pend_key_ff : '0, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SCAN_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (tail.found) begin
               count_in    = count_ff - 1'b1;
               nev_in      = nev_ff + 1'b1;
               pend_in     = 1'b1;
               pend_key_in = tail.key;
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: status_ff, evicted: 1'b1,
                             evicted_key: pend_key_ff, last: 1'b0};
               end
               state_in = ST_CHECK;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: status_ff, evicted: pend_ff,
                          evicted_key: pend_ff ? pend_key_ff : '0, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         pend_ff      <= 1'b0;
         nev_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         nev_ff       <= nev_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_data;
      scan_ff     <= scan_in;
      status_ff   <= status_in;
      pend_key_ff <= pend_key_in;
      rsp_ff      <= rsp_in;
   end

   `include "oldest_entry_eviction_with_locks_assert.svh"

   // checks
   `OEEL_ASSERT_SAME(a_count_matches, clock, reset, 1'b1, count_ff == CNT_W'($countones(slot_valid)))
   `OEEL_ASSERT_NEXT(a_more_follows, clock, reset, rsp_valid_ff && !rsp_ff.last, busy || rsp_valid_ff)
   `OEEL_ASSERT_SAME(a_no_key_without_evict, clock, reset, rsp_valid_ff && !rsp_ff.evicted, rsp_ff.evicted_key == '0)
   `OEEL_ASSERT_SAME(a_evict_cap, clock, reset, 1'b1, nev_ff <= NEV_W'(MAX_RESULTS))

endmodule
